// File: rtl/cia_pkg.sv
// shared types and constants for the interface adapter with timers
package cia_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_FLAG  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    REG_PRA    = 4'd0,
    REG_PRB    = 4'd1,
    REG_DDRA   = 4'd2,
    REG_DDRB   = 4'd3,
    REG_TA_LO  = 4'd4,
    REG_TA_HI  = 4'd5,
    REG_TB_LO  = 4'd6,
    REG_TB_HI  = 4'd7,
    REG_TOD_10 = 4'd8,
    REG_TOD_S  = 4'd9,
    REG_TOD_M  = 4'd10,
    REG_TOD_H  = 4'd11,
    REG_SDR    = 4'd12,
    REG_ICR    = 4'd13,
    REG_CRA    = 4'd14,
    REG_CRB    = 4'd15
  } reg_e;

  // control register bits
  localparam int unsigned CtrlStart   = 0;
  localparam int unsigned CtrlOneShot = 3;
  localparam int unsigned CtrlLoad    = 4;
  localparam int unsigned CraSpOut    = 6;
  localparam int unsigned CrbAlarm    = 7;

  // interrupt control bits
  localparam int unsigned IcrSetClr = 7;
  localparam int unsigned IntTimerA = 0;
  localparam int unsigned IntTimerB = 1;
  localparam int unsigned IntFlag   = 4;
  localparam int unsigned IntBits   = 5;

  localparam logic [7:0] TodMaskTenths = 8'h0F;
  localparam logic [7:0] TodMaskMid    = 8'h7F;
  localparam logic [7:0] TodMaskFull   = 8'hFF;

  typedef struct packed {
    op_e         op;
    reg_e        addr;
    logic [7:0]  wdata;
    logic [15:0] ticks;
    logic [7:0]  pa_pins;
    logic [7:0]  pb_pins;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       irq_changed;
    logic [7:0] pa_out;
    logic       pa_out_valid;
    logic [7:0] pb_out;
    logic       pb_out_valid;
    logic [7:0] sr_out;
    logic       sr_out_valid;
  } out_beat_t;

endpackage

// File: rtl/cia_if.sv
// valid/ready channel interfaces for the adapter's input and result streams
interface cia_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  addr;
  logic [7:0]  wdata;
  logic [15:0] ticks;
  logic [7:0]  pa_pins;
  logic [7:0]  pb_pins;

  modport source (output valid, op, addr, wdata, ticks, pa_pins, pb_pins, input ready);
  modport sink (input valid, op, addr, wdata, ticks, pa_pins, pb_pins, output ready);
endinterface

interface cia_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq;
  logic       irq_changed;
  logic [7:0] pa_out;
  logic       pa_out_valid;
  logic [7:0] pb_out;
  logic       pb_out_valid;
  logic [7:0] sr_out;
  logic       sr_out_valid;

  modport source (output valid, rdata, irq, irq_changed, pa_out, pa_out_valid, pb_out,
                  pb_out_valid, sr_out, sr_out_valid, input ready);
  modport sink (input valid, rdata, irq, irq_changed, pa_out, pa_out_valid, pb_out,
                pb_out_valid, sr_out, sr_out_valid, output ready);
endinterface

// File: rtl/complex_interface_adapter_timers.sv
// top level of the interface adapter: ports, timers, interrupt logic
//
// in_i carries one event per beat: a register read or write, a timer tick
// with an elapsed cycle count, or a flag pin event. out_o returns exactly one
// result beat per event: read data, interrupt level and change, port latches
// with re-drive strobes, and the serial byte with its send strobe.
//
// an event is held in the input register, is processed by the
// combinational update of the register file, and lands in the result
// register. one event per cycle is sustained while the receiver does not
// stall. state is updated when an event moves into the result register,
// so back-to-back events see each other's effects.
//
// when the receiver stalls, the result register holds, the input register
// fills with one more event, and then in_i.ready drops until out_o.ready
// returns. reset clears all registers, the timers and the interrupt state,
// and empties both stages; no clearing pass is needed.
module complex_interface_adapter_timers (
  input  logic     clk_i,
  input  logic     rst_ni,
  cia_in_if.sink   in_i,
  cia_out_if.source out_o
);

  logic                          in_v_q;
  cia_pkg::in_beat_t             in_q;
  logic                          out_v_q;
  cia_pkg::out_beat_t            out_q, out_d;
  logic                          advance;
  logic                          in_take;

  logic [7:0]  port_a_q, port_a_d, port_b_q, port_b_d;
  logic [7:0]  dir_a_q, dir_a_d, dir_b_q, dir_b_d;
  logic [15:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic [15:0] reload_a_q, reload_a_d, reload_b_q, reload_b_d;
  logic [7:0]  ctrl_a_q, ctrl_a_d, ctrl_b_q, ctrl_b_d;
  logic [7:0]  serial_q, serial_d;
  logic [7:0]  tod_q [4];
  logic [7:0]  tod_d [4];
  logic [cia_pkg::IntBits-1:0] mask_q, mask_d, flags_q, flags_d;
  logic        irq_q, irq_d;

  assign advance = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;
  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.op      <= cia_pkg::op_e'(in_i.op);
      in_q.addr    <= cia_pkg::reg_e'(in_i.addr);
      in_q.wdata   <= in_i.wdata;
      in_q.ticks   <= in_i.ticks;
      in_q.pa_pins <= in_i.pa_pins;
      in_q.pb_pins <= in_i.pb_pins;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    logic [7:0] rd;
    logic       pav, pbv, srv;
    rd = '0;
    pav = 1'b0;
    pbv = 1'b0;
    srv = 1'b0;
    port_a_d   = port_a_q;
    port_b_d   = port_b_q;
    dir_a_d    = dir_a_q;
    dir_b_d    = dir_b_q;
    count_a_d  = count_a_q;
    count_b_d  = count_b_q;
    reload_a_d = reload_a_q;
    reload_b_d = reload_b_q;
    ctrl_a_d   = ctrl_a_q;
    ctrl_b_d   = ctrl_b_q;
    serial_d   = serial_q;
    tod_d      = tod_q;
    mask_d     = mask_q;
    flags_d    = flags_q;

    unique case (in_q.op)
      cia_pkg::OP_READ: begin
        unique case (in_q.addr)
          cia_pkg::REG_PRA:    rd = in_q.pa_pins;
          cia_pkg::REG_PRB:    rd = in_q.pb_pins;
          cia_pkg::REG_DDRA:   rd = dir_a_q;
          cia_pkg::REG_DDRB:   rd = dir_b_q;
          cia_pkg::REG_TA_LO:  rd = count_a_q[7:0];
          cia_pkg::REG_TA_HI:  rd = count_a_q[15:8];
          cia_pkg::REG_TB_LO:  rd = count_b_q[7:0];
          cia_pkg::REG_TB_HI:  rd = count_b_q[15:8];
          cia_pkg::REG_TOD_10, cia_pkg::REG_TOD_S,
          cia_pkg::REG_TOD_M, cia_pkg::REG_TOD_H: rd = tod_q[in_q.addr[1:0]];
          cia_pkg::REG_SDR:    rd = serial_q;
          cia_pkg::REG_ICR: begin
            // bit 7 mirrors the line; the read acknowledges everything
            rd = {irq_q, 2'b00, flags_q};
            flags_d = '0;
          end
          cia_pkg::REG_CRA:    rd = ctrl_a_q;
          cia_pkg::REG_CRB:    rd = ctrl_b_q;
          default:             rd = '0;
        endcase
      end
      cia_pkg::OP_WRITE: begin
        unique case (in_q.addr)
          cia_pkg::REG_PRA: begin
            port_a_d = in_q.wdata;
            pav = 1'b1;
          end
          cia_pkg::REG_PRB: begin
            port_b_d = in_q.wdata;
            pbv = 1'b1;
          end
          cia_pkg::REG_DDRA: begin
            dir_a_d = in_q.wdata;
            pav = (dir_a_q != in_q.wdata);
          end
          cia_pkg::REG_DDRB: begin
            dir_b_d = in_q.wdata;
            pbv = (dir_b_q != in_q.wdata);
          end
          cia_pkg::REG_TA_LO: reload_a_d = {reload_a_q[15:8], in_q.wdata};
          cia_pkg::REG_TA_HI: begin
            reload_a_d = {in_q.wdata, reload_a_q[7:0]};
            if (!ctrl_a_q[cia_pkg::CtrlStart] || ctrl_a_q[cia_pkg::CtrlLoad]) begin
              count_a_d = {in_q.wdata, reload_a_q[7:0]};
            end
          end
          cia_pkg::REG_TB_LO: reload_b_d = {reload_b_q[15:8], in_q.wdata};
          cia_pkg::REG_TB_HI: begin
            reload_b_d = {in_q.wdata, reload_b_q[7:0]};
            if (!ctrl_b_q[cia_pkg::CtrlStart] || ctrl_b_q[cia_pkg::CtrlLoad]) begin
              count_b_d = {in_q.wdata, reload_b_q[7:0]};
            end
          end
          cia_pkg::REG_TOD_10, cia_pkg::REG_TOD_S,
          cia_pkg::REG_TOD_M, cia_pkg::REG_TOD_H: begin
            // alarm writes are dropped
            if (!ctrl_b_q[cia_pkg::CrbAlarm]) begin
              priority if (in_q.addr == cia_pkg::REG_TOD_10) begin
                tod_d[in_q.addr[1:0]] = in_q.wdata & cia_pkg::TodMaskTenths;
              end else if (in_q.addr == cia_pkg::REG_TOD_H) begin
                tod_d[in_q.addr[1:0]] = in_q.wdata & cia_pkg::TodMaskFull;
              end else begin
                tod_d[in_q.addr[1:0]] = in_q.wdata & cia_pkg::TodMaskMid;
              end
            end
          end
          cia_pkg::REG_SDR: begin
            serial_d = in_q.wdata;
            srv = ctrl_a_q[cia_pkg::CraSpOut];
          end
          cia_pkg::REG_ICR: begin
            if (in_q.wdata[cia_pkg::IcrSetClr]) begin
              mask_d = mask_q | in_q.wdata[cia_pkg::IntBits-1:0];
            end else begin
              mask_d = mask_q & ~in_q.wdata[cia_pkg::IntBits-1:0];
            end
          end
          cia_pkg::REG_CRA: begin
            ctrl_a_d = in_q.wdata;
            if (in_q.wdata[cia_pkg::CtrlLoad]) begin
              ctrl_a_d[cia_pkg::CtrlLoad] = 1'b0;
              count_a_d = reload_a_q;
            end
          end
          cia_pkg::REG_CRB: begin
            ctrl_b_d = in_q.wdata;
            if (in_q.wdata[cia_pkg::CtrlLoad]) begin
              ctrl_b_d[cia_pkg::CtrlLoad] = 1'b0;
              count_b_d = reload_b_q;
            end
          end
          default: ;
        endcase
      end
      cia_pkg::OP_TICK: begin
        if (ctrl_a_q[cia_pkg::CtrlStart]) begin
          if (count_a_q <= in_q.ticks) begin
            flags_d[cia_pkg::IntTimerA] = 1'b1;
            count_a_d = reload_a_q;
            if (ctrl_a_q[cia_pkg::CtrlOneShot]) begin
              ctrl_a_d[cia_pkg::CtrlStart] = 1'b0;
            end
          end else begin
            count_a_d = count_a_q - in_q.ticks;
          end
        end
        if (ctrl_b_q[cia_pkg::CtrlStart]) begin
          if (count_b_q <= in_q.ticks) begin
            flags_d[cia_pkg::IntTimerB] = 1'b1;
            count_b_d = reload_b_q;
            if (ctrl_b_q[cia_pkg::CtrlOneShot]) begin
              ctrl_b_d[cia_pkg::CtrlStart] = 1'b0;
            end
          end else begin
            count_b_d = count_b_q - in_q.ticks;
          end
        end
      end
      cia_pkg::OP_FLAG: flags_d[cia_pkg::IntFlag] = 1'b1;
      default: ;
    endcase

    irq_d = |(mask_d & flags_d);

    out_d.rdata        = rd;
    out_d.irq          = irq_d;
    out_d.irq_changed  = irq_d ^ irq_q;
    out_d.pa_out       = port_a_d;
    out_d.pa_out_valid = pav;
    out_d.pb_out       = port_b_d;
    out_d.pb_out_valid = pbv;
    out_d.sr_out       = serial_d;
    out_d.sr_out_valid = srv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q   <= '0;
      port_b_q   <= '0;
      dir_a_q    <= '0;
      dir_b_q    <= '0;
      count_a_q  <= '0;
      count_b_q  <= '0;
      reload_a_q <= '0;
      reload_b_q <= '0;
      ctrl_a_q   <= '0;
      ctrl_b_q   <= '0;
      serial_q   <= '0;
      tod_q      <= '{default: '0};
      mask_q     <= '0;
      flags_q    <= '0;
      irq_q      <= 1'b0;
    end else if (advance) begin
      port_a_q   <= port_a_d;
      port_b_q   <= port_b_d;
      dir_a_q    <= dir_a_d;
      dir_b_q    <= dir_b_d;
      count_a_q  <= count_a_d;
      count_b_q  <= count_b_d;
      reload_a_q <= reload_a_d;
      reload_b_q <= reload_b_d;
      ctrl_a_q   <= ctrl_a_d;
      ctrl_b_q   <= ctrl_b_d;
      serial_q   <= serial_d;
      tod_q      <= tod_d;
      mask_q     <= mask_d;
      flags_q    <= flags_d;
      irq_q      <= irq_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.rdata        = out_q.rdata;
  assign out_o.irq          = out_q.irq;
  assign out_o.irq_changed  = out_q.irq_changed;
  assign out_o.pa_out       = out_q.pa_out;
  assign out_o.pa_out_valid = out_q.pa_out_valid;
  assign out_o.pb_out       = out_q.pb_out;
  assign out_o.pb_out_valid = out_q.pb_out_valid;
  assign out_o.sr_out       = out_q.sr_out;
  assign out_o.sr_out_valid = out_q.sr_out_valid;

  // line level always follows enabled pending flags
  a_irq_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q == |(mask_q & flags_q))
    else $error("interrupt line out of step with mask and flags");

  // force-load bit is never left set in either control register
  a_load_bit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_a_q[cia_pkg::CtrlLoad] && !ctrl_b_q[cia_pkg::CtrlLoad])
    else $error("force-load bit left set");

  // acknowledge read clears flags and drops the line
  a_icr_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.op == cia_pkg::OP_READ && in_q.addr == cia_pkg::REG_ICR
    |=> flags_q == '0 && !irq_q)
    else $error("interrupt read did not clear flags");

  // reported change matches the line level across the event
  a_irq_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_q.irq_changed == (irq_q != $past(irq_q)) && out_q.irq == irq_q)
    else $error("interrupt change report wrong");

  // a stalled result beat stays valid and unchanged until it is taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_o.ready |=> out_v_q && $stable(out_q))
    else $error("result beat lost under stall");

endmodule
